FILE: src/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared definitions for the world to screen projection unit
// Default number formats, request and register codes, and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

    // Default fixed-point format: signed Q16.16.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Viewport dimension registers.
    localparam int DIM_W = 14;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Request types.
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    // Matrix addressing.
    localparam int COEFF_IDX_W = 4;
    localparam int NUM_COEFF   = 16;

endpackage

`default_nettype wire

FILE: src/world_to_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit: perspective projection pipeline
// Projects fixed-point world points to screen coordinates through a loaded
// view-projection matrix.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_valid / o_stall) carries two kinds of transfer.
// A load transfer writes one row-major matrix coefficient and produces no
// result. A project transfer carries a world point and produces exactly one
// result on the output channel (o_valid / i_stall): an in-front flag and the
// saturated screen x and y, both zero when the point is behind the viewer.
// Load all sixteen coefficients before projecting; the viewport width and
// height registers are written through the plain write port while idle.
// Throughput is one transfer per cycle while no result is stalled. A projection
// (signed Q16.16 by default) passes through three clip stages,
// one preparation stage, one stage per quotient bit in the two dividers,
// and three viewport stages ending in the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises; nothing is lost or repeated. Reset empties the pipeline and
// restores a 1920 by 1080 viewport; the matrix is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection_unit import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_req_type,
    input  wire logic [COEFF_IDX_W-1:0]        i_coeff_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_coeff_value,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_in_front,
    output logic signed [COORD_WIDTH-1:0]      o_screen_x,
    output logic signed [COORD_WIDTH-1:0]      o_screen_y,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [DIM_W-1:0]              i_cfg_data
);

    localparam int NW    = COORD_WIDTH + FRAC_BITS;
    // Smallest clip w counted as in front: 0.1 rounded up.
    localparam int W_MIN = ((1 << FRAC_BITS) + 9) / 10;

    logic                          w_en;
    logic                          w_accept;
    logic [DIM_W-1:0]              r_width, r_height;
    logic                          w_clip_valid;
    logic signed [COORD_WIDTH-1:0] w_clip_x, w_clip_y, w_clip_w;
    logic                          r_p_valid, r_p_front, r_p_neg_x, r_p_neg_y;
    logic [COORD_WIDTH-1:0]        r_p_mag_x, r_p_mag_y, r_p_den;
    logic                          w_div_vx, w_div_vy;
    logic [NW-1:0]                 w_quo_x, w_quo_y;
    logic [1:0]                    w_tag_x;
    logic                          w_tag_y;

    // The pipeline advances unless a finished result is waiting and stalled.
    assign w_en     = !o_valid || !i_stall;
    assign o_stall  = !w_en;
    assign w_accept = i_valid && w_en;

    // Viewport size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wsp_clip #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_clip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_load   (w_accept && (i_req_type == REQ_LOAD)),
        .i_index  (i_coeff_index),
        .i_coeff  (i_coeff_value),
        .i_proj   (w_accept && (i_req_type == REQ_PROJECT)),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .o_valid  (w_clip_valid),
        .o_clip_x (w_clip_x),
        .o_clip_y (w_clip_y),
        .o_clip_w (w_clip_w)
    );

    // Preparation stage: behind test and sign/magnitude split for division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_clip_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_front <= w_clip_w >= $signed(COORD_WIDTH'(W_MIN));
            r_p_neg_x <= w_clip_x[COORD_WIDTH-1];
            r_p_neg_y <= w_clip_y[COORD_WIDTH-1];
            r_p_mag_x <= w_clip_x[COORD_WIDTH-1] ? COORD_WIDTH'(-w_clip_x)
                                                 : COORD_WIDTH'(w_clip_x);
            r_p_mag_y <= w_clip_y[COORD_WIDTH-1] ? COORD_WIDTH'(-w_clip_y)
                                                 : COORD_WIDTH'(w_clip_y);
            r_p_den   <= w_clip_w;
        end
    end

    // Two dividers run side by side; the x lane carries the in-front flag and x sign, the y lane the y sign.
    wsp_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .TAG_W       (2)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_num   ({r_p_mag_x, {FRAC_BITS{1'b0}}}),
        .i_den   (r_p_den),
        .i_tag   ({r_p_front, r_p_neg_x}),
        .o_valid (w_div_vx),
        .o_quo   (w_quo_x),
        .o_tag   (w_tag_x)
    );

    wsp_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .TAG_W       (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_num   ({r_p_mag_y, {FRAC_BITS{1'b0}}}),
        .i_den   (r_p_den),
        .i_tag   (r_p_neg_y),
        .o_valid (w_div_vy),
        .o_quo   (w_quo_y),
        .o_tag   (w_tag_y)
    );

    wsp_view #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_view (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_div_vx),
        .i_front    (w_tag_x[1]),
        .i_neg_x    (w_tag_x[0]),
        .i_neg_y    (w_tag_y),
        .i_quo_x    (w_quo_x),
        .i_quo_y    (w_quo_y),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (o_valid),
        .o_in_front (o_in_front),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );

    // A hidden point always reports zero screen coordinates.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_front |-> o_screen_x == '0 && o_screen_y == '0)
        else $error("hidden point with nonzero screen coordinates");

    // Both divider lanes stay in lockstep.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_vx == w_div_vy)
        else $error("divider lanes out of step");

    // A held pipeline keeps its divider output in place.
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_vx && !w_en |=> w_div_vx && $stable(w_quo_x))
        else $error("divider output changed while the pipeline was held");

endmodule

`default_nettype wire

FILE: src/wsp_clip.sv
// ----------------------------------------------------------------------------
// wsp_clip: matrix store and clip-space transform
// Holds the 4x4 matrix and forms saturated clip x, y and w in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_clip import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_load,
    input  wire logic [COEFF_IDX_W-1:0]        i_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_coeff,
    input  wire logic                          i_proj,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_clip_x,
    output logic signed [COORD_WIDTH-1:0]      o_clip_y,
    output logic signed [COORD_WIDTH-1:0]      o_clip_w
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int AW = 2 * COORD_WIDTH + 2;
    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] r_coef [NUM_COEFF];
    logic signed [COORD_WIDTH-1:0] w_pos  [3];
    logic signed [PW-1:0]          r_prod [3][3];
    logic signed [COORD_WIDTH-1:0] r_bias [3];
    logic signed [AW-1:0]          r_sa   [3];
    logic signed [AW-1:0]          r_sb   [3];
    logic signed [COORD_WIDTH-1:0] r_clip [3];
    logic                          r_v1, r_v2, r_v3;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    // Loads land at their transfer, so a later projection sees them.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_coef[i_index] <= i_coeff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_proj;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_row
        // Lanes 0, 1 and 2 use matrix rows 0, 1 and 3.
        localparam int ROW = (l == 2) ? 3 : l;
        logic signed [AW-1:0] w_sum;
        logic signed [AW-1:0] w_sh;
        logic                 w_ovf;

        for (genvar j = 0; j < 3; j++) begin : g_mul
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod[l][j] <= w_pos[j] * r_coef[ROW*4 + j];
                end
            end
        end

        assign w_sum = r_sa[l] + r_sb[l];
        assign w_sh  = w_sum >>> FRAC_BITS;
        assign w_ovf = !((&w_sh[AW-1:COORD_WIDTH-1]) || !(|w_sh[AW-1:COORD_WIDTH-1]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bias[l] <= r_coef[ROW*4 + 3];
                r_sa[l]   <= AW'(r_prod[l][0]) + AW'(r_prod[l][1]);
                r_sb[l]   <= AW'(r_prod[l][2]) + (AW'(r_bias[l]) <<< FRAC_BITS);
                r_clip[l] <= w_ovf ? (w_sh[AW-1] ? SAT_MIN : SAT_MAX)
                                   : w_sh[COORD_WIDTH-1:0];
            end
        end
    end

    assign o_valid  = r_v3;
    assign o_clip_x = r_clip[0];
    assign o_clip_y = r_clip[1];
    assign o_clip_w = r_clip[2];

endmodule

`default_nettype wire

FILE: src/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div: pipelined restoring divider
// Unsigned quotient, one bit per stage, with a tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_div import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int TAG_W       = 1
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic [COORD_WIDTH+FRAC_BITS-1:0]     i_num,
    input  wire logic [COORD_WIDTH-1:0]               i_den,
    input  wire logic [TAG_W-1:0]                     i_tag,
    output logic                                      o_valid,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]          o_quo,
    output logic [TAG_W-1:0]                          o_tag
);

    localparam int NW = COORD_WIDTH + FRAC_BITS;

    logic                   r_vld [NW];
    logic [COORD_WIDTH-1:0] r_rem [NW];
    logic [NW-1:0]          r_num [NW];
    logic [NW-1:0]          r_quo [NW];
    logic [COORD_WIDTH-1:0] r_den [NW];
    logic [TAG_W-1:0]       r_tag [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic                   w_vld;
        logic [COORD_WIDTH-1:0] w_rem;
        logic [NW-1:0]          w_num;
        logic [NW-1:0]          w_quo;
        logic [COORD_WIDTH-1:0] w_den;
        logic [TAG_W-1:0]       w_tag;
        logic [COORD_WIDTH:0]   w_trial;
        logic                   w_ge;

        if (k == 0) begin : g_first
            assign w_vld = i_valid;
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_quo = '0;
            assign w_den = i_den;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_vld = r_vld[k-1];
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_quo = r_quo[k-1];
            assign w_den = r_den[k-1];
            assign w_tag = r_tag[k-1];
        end

        assign w_trial = {w_rem, w_num[NW-1]};
        assign w_ge    = w_trial >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? COORD_WIDTH'(w_trial - {1'b0, w_den})
                                 : w_trial[COORD_WIDTH-1:0];
                r_num[k] <= w_num << 1;
                r_quo[k] <= {w_quo[NW-2:0], w_ge};
                r_den[k] <= w_den;
                r_tag[k] <= w_tag;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_tag   = r_tag[NW-1];

endmodule

`default_nettype wire

FILE: src/wsp_view.sv
// ----------------------------------------------------------------------------
// wsp_view: viewport mapping
// Signs the quotients, scales them by hw + 1 and 1 - hh, adds the half window sizes and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_view import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic                              i_front,
    input  wire logic                              i_neg_x,
    input  wire logic                              i_neg_y,
    input  wire logic [COORD_WIDTH+FRAC_BITS-1:0]  i_quo_x,
    input  wire logic [COORD_WIDTH+FRAC_BITS-1:0]  i_quo_y,
    input  wire logic [DIM_W-1:0]                  i_width,
    input  wire logic [DIM_W-1:0]                  i_height,
    output logic                                   o_valid,
    output logic                                   o_in_front,
    output logic signed [COORD_WIDTH-1:0]          o_screen_x,
    output logic signed [COORD_WIDTH-1:0]          o_screen_y
);

    localparam int NW = COORD_WIDTH + FRAC_BITS;
    localparam int KW = DIM_W + 1;
    localparam int MW = NW + 1 + KW;
    localparam int SW = MW + 1;
    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [DIM_W-1:0]       w_hw, w_hh;
    logic signed [NW:0]     r_nx, r_ny;
    logic signed [KW-1:0]   r_kx, r_ky;
    logic signed [MW-1:0]   r_px, r_py;
    logic                   r_v1, r_v2, r_v3;
    logic                   r_f1, r_f2, r_f3;
    logic signed [COORD_WIDTH-1:0] r_sx, r_sy;
    logic signed [SW-1:0]   w_sx, w_sy;
    logic                   w_ovx, w_ovy;

    assign w_hw = i_width >> 1;
    assign w_hh = i_height >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // x scales by hw + 1 and y by 1 - hh.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= i_neg_x ? -$signed({1'b0, i_quo_x}) : $signed({1'b0, i_quo_x});
            r_ny <= i_neg_y ? -$signed({1'b0, i_quo_y}) : $signed({1'b0, i_quo_y});
            r_kx <= $signed({1'b0, w_hw}) + KW'(1);
            r_ky <= KW'(1) - $signed({1'b0, w_hh});
            r_f1 <= i_front;
            r_px <= MW'(r_nx) * MW'(r_kx);
            r_py <= MW'(r_ny) * MW'(r_ky);
            r_f2 <= r_f1;
        end
    end

    assign w_sx  = SW'(r_px) + (SW'($signed({1'b0, w_hw})) <<< FRAC_BITS);
    assign w_sy  = SW'(r_py) + (SW'($signed({1'b0, w_hh})) <<< FRAC_BITS);
    assign w_ovx = !((&w_sx[SW-1:COORD_WIDTH-1]) || !(|w_sx[SW-1:COORD_WIDTH-1]));
    assign w_ovy = !((&w_sy[SW-1:COORD_WIDTH-1]) || !(|w_sy[SW-1:COORD_WIDTH-1]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f3 <= r_f2;
            if (!r_f2) begin
                r_sx <= '0;
                r_sy <= '0;
            end else begin
                r_sx <= w_ovx ? (w_sx[SW-1] ? SAT_MIN : SAT_MAX) : w_sx[COORD_WIDTH-1:0];
                r_sy <= w_ovy ? (w_sy[SW-1] ? SAT_MIN : SAT_MAX) : w_sy[COORD_WIDTH-1:0];
            end
        end
    end

    assign o_valid    = r_v3;
    assign o_in_front = r_f3;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;

endmodule

`default_nettype wire
